// ----- design/srde_pkg.sv -----
// shared types, constants and reciprocal table for the signed radix digit emitter
package srde_pkg;

    // configuration port geometry
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned LEN_W    = 5;

    // item and result widths
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned SYMBOL_W = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned SLOTS    = 16;
    localparam int unsigned RECIP_W  = 32;

    // sign characters
    localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'd43;
    localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'd45;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_LENGTH  = 2'd0;
    localparam logic [1:0] REG_SYM_LOW = 2'd1;
    localparam logic [1:0] REG_SYM_HI  = 2'd2;

    typedef logic [SLOTS-1:0][SYMBOL_W-1:0] t_alphabet;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic next_mag_zero;
        logic neg;
        logic last_digit;
    } t_dp_status;

    // floor(2^32 / radix), radix 2 to 16
    function automatic logic [RECIP_W-1:0] recip(input logic [LEN_W-1:0] radix);
        logic [RECIP_W-1:0] r;
        case (radix)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/srde_cfg.sv -----
// configuration registers and alphabet validity check
module srde_cfg #(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srde_pkg::ADDR_W-1:0]        paddr,
    input  logic [srde_pkg::DATA_W-1:0]        pwdata,
    output logic [srde_pkg::DATA_W-1:0]        prdata,
    output logic [srde_pkg::LEN_W-1:0]         o_radix,
    output srde_pkg::t_alphabet                o_alphabet,
    output logic                               o_alpha_ok
);
    import srde_pkg::*;

    logic [LEN_W-1:0]  r_length;
    logic [DATA_W-1:0] r_sym_low;
    logic [DATA_W-1:0] r_sym_hi;
    logic              wr_en;
    logic [1:0]        reg_idx;
    logic [LEN_W-1:0]  eff_len;
    logic              bad;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length  <= '0;
            r_sym_low <= '0;
            r_sym_hi  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LENGTH:  r_length  <= pwdata[LEN_W-1:0];
                REG_SYM_LOW: r_sym_low <= pwdata;
                REG_SYM_HI:  r_sym_hi  <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_LENGTH:  prdata = {{(DATA_W-LEN_W){1'b0}}, r_length};
            REG_SYM_LOW: prdata = r_sym_low;
            REG_SYM_HI:  prdata = r_sym_hi;
            default:     prdata = '0;
        endcase
    end

    // length saturated at the cap
    assign eff_len    = (r_length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : r_length;
    assign o_radix    = eff_len;
    assign o_alphabet = {r_sym_hi, r_sym_low};

    // sign characters and duplicates among symbols in use
    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if ((LEN_W'(i) < eff_len) &&
                ((o_alphabet[i] == SYM_PLUS) || (o_alphabet[i] == SYM_MINUS))) begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < SLOTS; j++) begin
                if ((LEN_W'(j) < eff_len) && (o_alphabet[i] == o_alphabet[j])) begin
                    bad = 1'b1;
                end
            end
        end
    end

    assign o_alpha_ok = (eff_len >= LEN_W'(2)) && !bad;

endmodule

// ----- design/srde_ctrl.sv -----
// sequencing state machine: divide loop, sign, digit pops
module srde_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    i_alpha_ok,
    input  srde_pkg::t_dp_status    i_status,
    output srde_pkg::t_dp_cmd       o_cmd,
    output logic                    busy
);
    import srde_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start && i_alpha_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.next_mag_zero) begin
                    n_state = i_status.neg ? S_SIGN : S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.last_digit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // a minus sign only goes out for a negative value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_sign |-> i_status.neg)
        else $error("minus sign issued for a non-negative value");

    // busy rises only after a loaded transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !$past(busy) && $past(i_rst_n)) |-> $past(o_cmd.load))
        else $error("work started without an accepted transfer");

endmodule

// ----- design/srde_dp.sv -----
// datapath: magnitude, reciprocal divide, digit stack, result register
module srde_dp #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  srde_pkg::t_dp_cmd                  i_cmd,
    input  logic [srde_pkg::VALUE_W-1:0]       i_value,
    input  logic [srde_pkg::LEN_W-1:0]         i_radix,
    input  srde_pkg::t_alphabet                i_alphabet,
    output srde_pkg::t_dp_status               o_status,
    output logic                               o_valid,
    output logic [srde_pkg::SYMBOL_W-1:0]      o_symbol,
    output logic                               o_last
);
    import srde_pkg::*;

    localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int unsigned PROD_W = VALUE_BITS + RECIP_W;

    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [PROD_W-1:0]     r_prod;
    logic [DIGIT_W-1:0]    r_stack [VALUE_BITS];
    logic [CNT_W-1:0]      r_count;
    logic                  r_valid;
    logic [SYMBOL_W-1:0]   r_symbol;
    logic                  r_last;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] q_est;
    logic [10:0]           qr_full;
    logic [5:0]            rem6;
    logic                  fix;
    logic [5:0]            rem_fixed;
    logic [DIGIT_W-1:0]    digit;
    logic [VALUE_BITS-1:0] n_mag_div;

    assign raw = i_value[VALUE_BITS-1:0];

    // quotient estimate is low by at most one; remainder fits in six bits
    assign q_est     = r_prod[PROD_W-1:RECIP_W];
    assign qr_full   = 11'(q_est[5:0]) * 11'(i_radix);
    assign rem6      = r_mag[5:0] - qr_full[5:0];
    assign fix       = (rem6 >= {1'b0, i_radix});
    assign rem_fixed = fix ? (rem6 - {1'b0, i_radix}) : rem6;
    assign digit     = rem_fixed[DIGIT_W-1:0];
    assign n_mag_div = q_est + VALUE_BITS'(fix);

    // magnitude and product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= raw[VALUE_BITS-1];
            r_mag <= raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
        end else if (i_cmd.div) begin
            r_mag <= n_mag_div;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(recip(i_radix));
        end
    end

    // digit stack: push on divide, pop on emit, top at entry zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.div) begin
            r_stack[0] <= digit;
            for (int k = 1; k < VALUE_BITS; k++) begin
                r_stack[k] <= r_stack[k-1];
            end
        end else if (i_cmd.emit_digit) begin
            for (int k = 0; k < VALUE_BITS - 1; k++) begin
                r_stack[k] <= r_stack[k+1];
            end
            r_stack[VALUE_BITS-1] <= '0;
        end
    end

    // stack depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.div) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.emit_digit) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // result register, loaded on each sign or digit emit command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_sign | i_cmd.emit_digit;
        end
        if (i_cmd.emit_sign) begin
            r_symbol <= SYM_MINUS;
            r_last   <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_symbol <= i_alphabet[r_stack[0]];
            r_last   <= o_status.last_digit;
        end
    end

    assign o_status.next_mag_zero = (n_mag_div == '0);
    assign o_status.neg           = r_neg;
    assign o_status.last_digit    = (r_count == CNT_W'(1));

    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

    // each pushed digit is below the radix
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |=> ({1'b0, r_stack[0]} < i_radix))
        else $error("digit out of range for the radix");

    // never pop an empty stack
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |-> (r_count != '0))
        else $error("digit emitted from an empty stack");

    // a last transfer leaves the stack empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_count == '0))
        else $error("last symbol sent with digits still stacked");

endmodule

// ----- design/signed_radix_digit_emitter.sv -----
// top level: signed value to symbol stream in a configured radix
// operation: per digit a multiply step and a divide and correct step; the symbols then
//   follow on the result ports, one symbol per cycle, a minus sign first for a negative value
// an invalid alphabet drops the item at once
// reset: synchronous active low, clears configuration, state machine and strobe
module signed_radix_digit_emitter #(
    parameter int unsigned MAX_SYMBOLS = 16,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srde_pkg::ADDR_W-1:0]        paddr,
    input  logic [srde_pkg::DATA_W-1:0]        pwdata,
    output logic [srde_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic [srde_pkg::VALUE_W-1:0]       i_value,
    output logic                               o_valid,
    output logic [srde_pkg::SYMBOL_W-1:0]      o_symbol,
    output logic                               o_last
);
    import srde_pkg::*;

    logic [LEN_W-1:0] radix;
    t_alphabet        alphabet;
    logic             alpha_ok;
    t_dp_cmd          cmd;
    t_dp_status       status;

    assign pready = 1'b1;

    // configuration registers
    srde_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .o_radix    (radix),
        .o_alphabet (alphabet),
        .o_alpha_ok (alpha_ok)
    );

    // controller
    srde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_alpha_ok (alpha_ok),
        .i_status   (status),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // datapath
    srde_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_value),
        .i_radix    (radix),
        .i_alphabet (alphabet),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_symbol   (o_symbol),
        .o_last     (o_last)
    );

endmodule
